@@ hdl/pnfp_pkg.sv @@
// Package for the packet name field parser.
// Result record, phase and kind codes, output queue sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pnfp_pkg;

  typedef enum logic [2:0] {
    PH_META = 3'd0,
    PH_SHIP = 3'd1,
    PH_RIFT = 3'd2,
    PH_BLOQ = 3'd3,
    PH_FRAG = 3'd4,
    PH_PLEN = 3'd5,
    PH_PATH = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PATH = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   path_byte;
    logic [63:0]  ship_low;
    logic [63:0]  ship_high;
    logic [31:0]  rift_value;
    logic [7:0]   bloq_value;
    logic [31:0]  fragment_number;
    logic         init_flag;
    logic         auth_flag;
    logic [15:0]  path_length;
    logic [16:0]  bytes_consumed;
  } result_t;

  // Up to two results per input byte, compacted so that res0 goes first.
  typedef struct packed {
    logic [1:0] n;
    result_t    res0;
    result_t    res1;
  } push_t;

  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned PTR_W     = $clog2(OUT_DEPTH);
  localparam int unsigned CNT_W     = $clog2(OUT_DEPTH + 1);

endpackage

`default_nettype wire

@@ hdl/pnfp_decoder.sv @@
// Field state machine of the name parser: one byte per transfer, up to two results.
// Depends on pnfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnfp_decoder
  import pnfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output push_t           push_o
);

  phase_e        phase_q, phase_d;
  logic [3:0]    idx_q, idx_d;
  logic [1:0]    rank_q, rank_d;
  logic [1:0]    riftw_q, riftw_d;
  logic [1:0]    fragw_q, fragw_d;
  logic [1:0]    flags_q, flags_d;
  logic [127:0]  ship_q, ship_d;
  logic [31:0]   rift_q, rift_d;
  logic [7:0]    bloq_q, bloq_d;
  logic [31:0]   frag_q, frag_d;
  logic [15:0]   plen_q, plen_d;
  logic [15:0]   rem_q, rem_d;
  logic [16:0]   cons_q, cons_d;

  logic          complete;
  logic          fail;
  logic          path_out;
  logic          no_tail;
  logic [4:0]    idx_inc;
  logic [4:0]    ship_len;
  result_t       path_res;
  result_t       tail_res;

  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    rank_d   = rank_q;
    riftw_d  = riftw_q;
    fragw_d  = fragw_q;
    flags_d  = flags_q;
    ship_d   = ship_q;
    rift_d   = rift_q;
    bloq_d   = bloq_q;
    frag_d   = frag_q;
    plen_d   = plen_q;
    rem_d    = rem_q;
    cons_d   = cons_q + 17'd1;
    complete = 1'b0;
    fail     = 1'b0;
    path_out = 1'b0;
    no_tail  = 1'b0;
    idx_inc  = {1'b0, idx_q} + 5'd1;
    ship_len = 5'd2 << rank_q;

    case (phase_q)
      PH_SHIP: begin
        ship_d[{idx_q, 3'b000} +: 8] = ship_q[{idx_q, 3'b000} +: 8] | byte_i;
        idx_d = idx_inc[3:0];
        if (idx_inc >= ship_len) begin
          idx_d   = 4'd0;
          phase_d = PH_RIFT;
        end
      end
      PH_RIFT: begin
        rift_d[{idx_q[1:0], 3'b000} +: 8] = rift_q[{idx_q[1:0], 3'b000} +: 8] | byte_i;
        idx_d = idx_inc[3:0];
        if (idx_inc > {3'b000, riftw_q}) begin
          idx_d   = 4'd0;
          phase_d = PH_BLOQ;
        end
      end
      PH_BLOQ: begin
        bloq_d  = byte_i;
        idx_d   = 4'd0;
        phase_d = flags_q[0] ? PH_PLEN : PH_FRAG;
      end
      PH_FRAG: begin
        frag_d[{idx_q[1:0], 3'b000} +: 8] = frag_q[{idx_q[1:0], 3'b000} +: 8] | byte_i;
        idx_d = idx_inc[3:0];
        if (idx_inc > {3'b000, fragw_q}) begin
          idx_d   = 4'd0;
          phase_d = PH_PLEN;
        end
      end
      PH_PLEN: begin
        if (idx_q == 4'd0) begin
          plen_d = {8'h00, byte_i};
        end else begin
          plen_d = plen_q | {byte_i, 8'h00};
        end
        idx_d = idx_inc[3:0];
        if (idx_inc >= 5'd2) begin
          idx_d = 4'd0;
          rem_d = plen_d;
          if (plen_d == 16'd0) begin
            complete = 1'b1;
          end else begin
            phase_d = PH_PATH;
          end
        end
      end
      PH_PATH: begin
        path_out = 1'b1;
        rem_d    = rem_q - 16'd1;
        if (rem_d == 16'd0) begin
          complete = 1'b1;
        end
      end
      default: begin
        // Meta byte; unused phase codes land here too.
        idx_d   = 4'd0;
        ship_d  = '0;
        rift_d  = '0;
        bloq_d  = '0;
        frag_d  = '0;
        plen_d  = '0;
        rem_d   = '0;
        cons_d  = 17'd1;
        rank_d  = byte_i[1:0];
        riftw_d = byte_i[3:2];
        flags_d = byte_i[5:4];
        fragw_d = byte_i[7:6];
        if (byte_i[5:4] == 2'b11) begin
          fail    = 1'b1;
          no_tail = 1'b1;
          phase_d = PH_META;
        end else begin
          phase_d = PH_SHIP;
        end
      end
    endcase

    if (!no_tail) begin
      if (complete) begin
        phase_d = PH_META;
      end else if (last_i) begin
        fail    = 1'b1;
        phase_d = PH_META;
      end
    end
  end

  always_comb begin
    path_res           = '0;
    path_res.kind      = KIND_PATH;
    path_res.path_byte = byte_i;

    tail_res      = '0;
    tail_res.kind = KIND_FAIL;
    if (complete) begin
      tail_res.kind            = KIND_DONE;
      tail_res.ship_low        = ship_d[63:0];
      tail_res.ship_high       = ship_d[127:64];
      tail_res.rift_value      = rift_d;
      tail_res.bloq_value      = bloq_d;
      tail_res.fragment_number = frag_d;
      tail_res.init_flag       = flags_d[0];
      tail_res.auth_flag       = flags_d[1];
      tail_res.path_length     = plen_d;
      tail_res.bytes_consumed  = cons_d;
    end

    push_o.res0 = tail_res;
    push_o.res1 = tail_res;
    push_o.n    = 2'd0;
    if (accept_i) begin
      if (path_out) begin
        push_o.res0 = path_res;
        push_o.n    = (complete || fail) ? 2'd2 : 2'd1;
      end else if (complete || fail) begin
        push_o.n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_META;
      idx_q   <= '0;
      rank_q  <= '0;
      riftw_q <= '0;
      fragw_q <= '0;
      flags_q <= '0;
      ship_q  <= '0;
      rift_q  <= '0;
      bloq_q  <= '0;
      frag_q  <= '0;
      plen_q  <= '0;
      rem_q   <= '0;
      cons_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      rank_q  <= rank_d;
      riftw_q <= riftw_d;
      fragw_q <= fragw_d;
      flags_q <= flags_d;
      ship_q  <= ship_d;
      rift_q  <= rift_d;
      bloq_q  <= bloq_d;
      frag_q  <= frag_d;
      plen_q  <= plen_d;
      rem_q   <= rem_d;
      cons_q  <= cons_d;
    end
  end

  // A byte flagged as last always returns the parser to the meta phase.
  a_last_ends_name : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> phase_q == PH_META)
    else $error("parser not back in meta phase after last byte");

  // Path phase is only ever entered with bytes still to come.
  a_path_remaining : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PATH |-> rem_q != 16'd0)
    else $error("path phase with nothing remaining");

  // Inside a name the byte count has been started by the meta byte.
  a_count_started : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_META |-> cons_q != 17'd0)
    else $error("byte count zero inside a name");

endmodule

`default_nettype wire

@@ hdl/pnfp_out_fifo.sv @@
// Result queue of the name parser: two writes and one read per cycle.
// Depends on pnfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pnfp_out_fifo
  import pnfp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       space2_o,
  output logic       valid_o,
  input  wire logic  ready_i,
  output result_t    data_o
);

  result_t           entry_q [OUT_DEPTH];
  logic [PTR_W-1:0]  wr_q;
  logic [PTR_W-1:0]  rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              pop;

  assign valid_o  = cnt_q != '0;
  assign pop      = valid_o && ready_i;
  assign data_o   = entry_q[rd_q];
  assign space2_o = cnt_q <= CNT_W'(OUT_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      entry_q[wr_q] <= push_i.res0;
    end
    if (push_i.n == 2'd2) begin
      entry_q[wr_q + PTR_W'(1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PTR_W'(push_i.n);
      rd_q  <= rd_q + PTR_W'(pop);
      cnt_q <= cnt_q + CNT_W'(push_i.n) - CNT_W'(pop);
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(push_i.n) <= CNT_W'(OUT_DEPTH) - cnt_q + CNT_W'(pop))
    else $error("result queue overflow");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(OUT_DEPTH))
    else $error("result queue count out of range");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n == 2'd0 && !pop |=> $stable(cnt_q))
    else $error("result queue count moved without a transfer");

endmodule

`default_nettype wire

@@ hdl/packet_name_field_parser.sv @@
// Top level of the packet name field parser.
// Depends on pnfp_pkg, pnfp_decoder and pnfp_out_fifo.
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial decoder for the name section of a packet. Each input transfer
// carries one byte and a flag marking the last byte available. The first
// byte of a name is the meta byte (rank, rift width, init, auth, fragment
// width); ship, rift, bloq, fragment (skipped for init names), a 2-byte path
// length and the path follow, all little endian. Every path byte leaves as
// a result of kind 0; the byte that ends the name is followed by a kind 1
// result holding all decoded fields and the byte count. Kind 2 reports a
// failure: init and auth both set, or the buffer ending mid-name; the parser
// then expects a fresh meta byte. A byte is accepted every cycle while
// input ready is high; its results are queued at once. Results pass
// through a four-entry queue; input ready drops only while fewer than two
// entries are free, which happens when the output side stalls, since a
// single byte can yield two results (last path byte plus completion).

module packet_name_field_parser
  import pnfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        buffer_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       path_byte_o,
  output logic [63:0]      ship_low_o,
  output logic [63:0]      ship_high_o,
  output logic [31:0]      rift_value_o,
  output logic [7:0]       bloq_value_o,
  output logic [31:0]      fragment_number_o,
  output logic             init_flag_o,
  output logic             auth_flag_o,
  output logic [15:0]      path_length_o,
  output logic [16:0]      bytes_consumed_o
);

  logic    in_xfer;
  push_t   push;
  result_t res;

  // Input transfer: one byte goes straight into the field state machine.
  assign in_xfer = in_valid_i && in_ready_o;

  pnfp_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .byte_i   (byte_in_i),
    .last_i   (buffer_end_i),
    .push_o   (push)
  );

  // Queue registers part the output handshake from the input side.
  pnfp_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .space2_o (in_ready_o),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (res)
  );

  assign kind_o            = res.kind;
  assign path_byte_o       = res.path_byte;
  assign ship_low_o        = res.ship_low;
  assign ship_high_o       = res.ship_high;
  assign rift_value_o      = res.rift_value;
  assign bloq_value_o      = res.bloq_value;
  assign fragment_number_o = res.fragment_number;
  assign init_flag_o       = res.init_flag;
  assign auth_flag_o       = res.auth_flag;
  assign path_length_o     = res.path_length;
  assign bytes_consumed_o  = res.bytes_consumed;

  // Results only come from accepted bytes.
  a_push_needs_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n != 2'd0 |-> in_xfer)
    else $error("result produced without an input transfer");

  // A path byte never carries name fields; a failure carries nothing.
  a_path_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (res.kind == KIND_PATH || res.kind == KIND_FAIL)
      |-> res.bytes_consumed == 17'd0)
    else $error("stray fields on a path or failure result");

  // A completed name never has both init and auth set.
  a_done_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res.kind == KIND_DONE |-> !(res.init_flag && res.auth_flag))
    else $error("completion with init and auth both set");

endmodule

`default_nettype wire
